### rtl/core/smau_pkg.sv
// shared types and constants for the stack machine arithmetic unit
package smau_pkg;

  localparam int DATA_W          = 32;
  localparam int CNT_W           = 9;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int MIN_OPERANDS    = 2;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MUL  = 3'd4,
    MODE_MOD  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [CNT_W-1:0]         stack_count;
    status_t                  status;
  } out_item_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic  start;
    mode_t op;
  } alu_ctl_t;

endpackage

### rtl/core/stack_machine_arith_unit.sv
// Stack machine arithmetic unit: bounded word stack with push and binary arithmetic.
// Push, short or full stack and unused modes go from idle straight to the done state;
// the other modes first read the second operand, a zero divisor ending the item there,
// then run in the shared adder of the ALU, div and mod one bit per cycle. One item at
// a time; the next input transfer is taken the cycle after the result is registered.
// Reset clears the entry count and handshake state; the stack memory is not cleared.
module stack_machine_arith_unit #(
  parameter int STACK_DEPTH = smau_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smau_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smau_pkg::out_item_t out_data
);
  import smau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [DATA_W-1:0] top_r;
  logic [2:0]        mode_r;
  status_t           status_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_xfer;
  logic              out_free;
  logic [CW-1:0]     count_m2;
  logic              is_full;
  logic              is_short;
  logic              is_divmod;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  alu_ctl_t          alu_ctl;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign count_m2  = count_r - CW'(MIN_OPERANDS);
  assign is_full   = (count_r == CW'(STACK_DEPTH));
  assign is_short  = (count_r < CW'(MIN_OPERANDS));
  assign is_divmod = (mode_r == MODE_DIV) || (mode_r == MODE_MOD);

  // memory write: push at the count, binary result over the second entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = in_data.push_value;
    if (state_r == S_IDLE) begin
      ram_we = in_xfer && (in_data.mode == MODE_PUSH) && !is_full;
    end else if (state_r == S_EXEC) begin
      ram_we    = alu_done;
      ram_waddr = count_m2[AW-1:0];
      ram_wdata = alu_result;
    end
  end

  // kick the arithmetic unit once the second operand is back
  always_comb begin
    alu_ctl.start = (state_r == S_READ) && !(is_divmod && (top_r == '0));
    alu_ctl.op    = mode_t'(mode_r);
  end

  smau_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (count_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  smau_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a      (ram_rdata),
    .b      (top_r),
    .done   (alu_done),
    .result (alu_result)
  );

  // sequencer, stack pointer, cached top and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: set on load, cleared on transfer
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mode_r <= in_data.mode;
            if (in_data.mode == MODE_PUSH) begin
              state_r <= S_DONE;
              if (is_full) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                top_r    <= in_data.push_value;
                count_r  <= count_r + CW'(1);
              end
            end else if (in_data.mode <= MODE_MOD) begin
              if (is_short) begin
                status_r <= ST_SHORT;
                state_r  <= S_DONE;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_READ;
              end
            end else begin
              status_r <= ST_OK;
              state_r  <= S_DONE;
            end
          end
        end
        S_READ: begin
          if (alu_ctl.start) begin
            state_r <= S_EXEC;
          end else begin
            status_r <= ST_DIVZERO;
            state_r  <= S_DONE;
          end
        end
        S_EXEC: begin
          if (alu_done) begin
            top_r   <= alu_result;
            count_r <= count_r - CW'(1);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.top_value   <= (count_r == '0) ? '0 : top_r;
            out_data_r.stack_count <= CNT_W'(count_r);
            out_data_r.status      <= status_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/smau_ram.sv
// generic single write port ram with registered read
module smau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/smau_alu.sv
// iterative arithmetic unit: one shared adder for add, sub, shift-add multiply and restoring divide
module smau_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  smau_pkg::alu_ctl_t               ctl,
  input  logic [smau_pkg::DATA_W-1:0]      a,
  input  logic [smau_pkg::DATA_W-1:0]      b,
  output logic                             done,
  output logic [smau_pkg::DATA_W-1:0]      result
);
  import smau_pkg::*;

  localparam int ITER_W = $clog2(DATA_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } astate_t;

  astate_t           state_r;
  mode_t             op_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] y_r;
  logic [ITER_W-1:0] iter_r;
  logic              neg_q_r;
  logic              neg_r_r;
  logic [DATA_W-1:0] res_r;
  logic              done_r;

  logic [DATA_W:0]   opa;
  logic [DATA_W:0]   opb;
  logic              sub;
  logic [DATA_W+1:0] sum;
  logic              qbit;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  // operand selection for the shared adder
  always_comb begin
    opa = {1'b0, acc_r};
    opb = {1'b0, x_r};
    sub = 1'b0;
    unique case (op_r)
      MODE_SUB: begin
        sub = 1'b1;
      end
      MODE_MUL: begin
        opb = y_r[0] ? {1'b0, x_r} : '0;
      end
      MODE_DIV, MODE_MOD: begin
        opa = {acc_r, y_r[DATA_W-1]};
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
  end

  // shared adder, carry out marks no borrow on subtract
  assign sum  = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (DATA_W+2)'(sub);
  assign qbit = sum[DATA_W+1];

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      op_r    <= MODE_ADD;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          done_r <= 1'b0;
          if (ctl.start) begin
            op_r    <= ctl.op;
            iter_r  <= '0;
            state_r <= A_RUN;
            unique case (ctl.op)
              MODE_MUL: begin
                acc_r <= '0;
                x_r   <= a;
                y_r   <= b;
              end
              MODE_DIV, MODE_MOD: begin
                acc_r   <= '0;
                x_r     <= mag(b);
                y_r     <= mag(a);
                neg_q_r <= a[DATA_W-1] ^ b[DATA_W-1];
                neg_r_r <= a[DATA_W-1];
              end
              default: begin
                acc_r <= a;
                x_r   <= b;
              end
            endcase
          end
        end
        A_RUN: begin
          unique case (op_r)
            MODE_MUL: begin
              acc_r  <= sum[DATA_W-1:0];
              x_r    <= {x_r[DATA_W-2:0], 1'b0};
              y_r    <= {1'b0, y_r[DATA_W-1:1]};
              iter_r <= iter_r + ITER_W'(1);
              if (iter_r == ITER_LAST) begin
                res_r   <= sum[DATA_W-1:0];
                done_r  <= 1'b1;
                state_r <= A_IDLE;
              end else begin
                done_r  <= 1'b0;
              end
            end
            MODE_DIV, MODE_MOD: begin
              done_r <= 1'b0;
              acc_r  <= qbit ? sum[DATA_W-1:0] : opa[DATA_W-1:0];
              y_r    <= {y_r[DATA_W-2:0], qbit};
              iter_r <= iter_r + ITER_W'(1);
              if (iter_r == ITER_LAST) begin
                state_r <= A_FIX;
              end
            end
            default: begin
              res_r   <= sum[DATA_W-1:0];
              done_r  <= 1'b1;
              state_r <= A_IDLE;
            end
          endcase
        end
        A_FIX: begin
          // sign fix: quotient by sign difference, remainder by dividend sign
          if (op_r == MODE_DIV) begin
            res_r <= neg_q_r ? (~y_r + DATA_W'(1)) : y_r;
          end else begin
            res_r <= neg_r_r ? (~acc_r + DATA_W'(1)) : acc_r;
          end
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
